// ----- rtl/core/rfp_pkg.sv -----
`timescale 1ns / 1ps

package rfp_pkg;

    // Largest payload length a reply may announce
    localparam logic [5:0] BUFFER_SIZE = 6'd32;

    // Result queue depth
    localparam int unsigned FIFO_DEPTH = 3;

    // Frame constants
    localparam logic [7:0] CMD_FLAG = 8'h80;
    localparam logic [5:0] LEN_MASK = 6'h3F;
    localparam logic [7:0] ERR_CODE = 8'hFF;
    localparam logic [7:0] CMD_MAX  = 8'd127;

    // Parser phases
    localparam logic [2:0] PH_RESULT   = 3'd0;
    localparam logic [2:0] PH_ERR_DEV  = 3'd1;
    localparam logic [2:0] PH_ERR_INFO = 3'd2;
    localparam logic [2:0] PH_CODE     = 3'd3;
    localparam logic [2:0] PH_CHECK    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD  = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DEV_ERR   = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_WRONG_CMD = 3'd3;
    localparam logic [2:0] ST_FLAG      = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;
    localparam logic [2:0] ST_CHECKSUM  = 3'd6;
    localparam logic [2:0] ST_NO_CMD    = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_EXP_CMD   = 2'd0;
    localparam logic [1:0] CFG_USE_CK    = 2'd1;
    localparam logic [1:0] CFG_EXP_BYTES = 2'd2;

    typedef struct packed {
        logic [7:0] expected_command;
        logic       use_checksum;
        logic [7:0] expected_bytes;
    } t_cfg;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_done;
        logic [2:0] status;
        logic [7:0] device_code;
        logic [7:0] error_info;
        logic [5:0] received_count;
    } t_result;

    // 8-bit end-around-carry add
    function automatic logic [7:0] sum_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

// ----- rtl/core/rfp_parse.sv -----
`timescale 1ns / 1ps

module rfp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  rfp_pkg::t_cfg       i_cfg,
    output logic                o_res_valid,
    output rfp_pkg::t_result    o_res
);

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [5:0] r_left, n_left;
    logic [5:0] r_taken, n_taken;
    logic [7:0] r_check, n_check;
    logic [7:0] r_dev, n_dev;
    logic       r_fhc, n_fhc;

    always_comb begin
        logic [5:0] len;
        logic       flag;
        logic [7:0] ck;
        logic [5:0] left_new;

        len      = i_byte[5:0] & rfp_pkg::LEN_MASK;
        flag     = i_byte[7];
        ck       = '0;
        left_new = '0;

        n_phase = r_phase;
        n_sum   = r_sum;
        n_left  = r_left;
        n_taken = r_taken;
        n_check = r_check;
        n_dev   = r_dev;
        n_fhc   = r_fhc;

        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_valid) begin
            unique case (r_phase)
                rfp_pkg::PH_RESULT: begin
                    if (i_cfg.expected_command > rfp_pkg::CMD_MAX) begin
                        o_res_valid       = 1'b1;
                        o_res.frame_done  = 1'b1;
                        o_res.status      = rfp_pkg::ST_NO_CMD;
                    end else if (i_byte == rfp_pkg::ERR_CODE) begin
                        n_phase = rfp_pkg::PH_ERR_DEV;
                    end else if (i_byte == 8'd0) begin
                        o_res_valid       = 1'b1;
                        o_res.frame_done  = 1'b1;
                        o_res.status      = rfp_pkg::ST_INVALID;
                    end else if (i_byte != (i_cfg.expected_command | rfp_pkg::CMD_FLAG)) begin
                        o_res_valid       = 1'b1;
                        o_res.frame_done  = 1'b1;
                        o_res.status      = rfp_pkg::ST_WRONG_CMD;
                    end else begin
                        n_sum   = i_byte;
                        n_taken = '0;
                        n_phase = rfp_pkg::PH_CODE;
                    end
                end
                rfp_pkg::PH_ERR_DEV: begin
                    n_dev   = i_byte;
                    n_phase = rfp_pkg::PH_ERR_INFO;
                end
                rfp_pkg::PH_ERR_INFO: begin
                    o_res_valid       = 1'b1;
                    o_res.frame_done  = 1'b1;
                    o_res.status      = rfp_pkg::ST_DEV_ERR;
                    o_res.device_code = r_dev;
                    o_res.error_info  = i_byte;
                end
                rfp_pkg::PH_CODE: begin
                    left_new = ({2'b00, len} > i_cfg.expected_bytes)
                             ? i_cfg.expected_bytes[5:0] : len;
                    if (flag != i_cfg.use_checksum) begin
                        o_res_valid      = 1'b1;
                        o_res.frame_done = 1'b1;
                        o_res.status     = rfp_pkg::ST_FLAG;
                    end else if (len > rfp_pkg::BUFFER_SIZE) begin
                        o_res_valid      = 1'b1;
                        o_res.frame_done = 1'b1;
                        o_res.status     = rfp_pkg::ST_TOO_LONG;
                    end else begin
                        n_sum   = rfp_pkg::sum_add(r_sum, i_byte);
                        n_fhc   = flag;
                        n_check = '0;
                        n_left  = left_new;
                        if (flag) begin
                            n_phase = rfp_pkg::PH_CHECK;
                        end else if (left_new == '0) begin
                            // no check byte, nothing to read: frame is good
                            o_res_valid      = 1'b1;
                            o_res.frame_done = 1'b1;
                            o_res.status     = rfp_pkg::ST_OK;
                        end else begin
                            n_phase = rfp_pkg::PH_PAYLOAD;
                        end
                    end
                end
                rfp_pkg::PH_CHECK: begin
                    n_check = i_byte;
                    ck      = ~r_sum;
                    if (r_left == '0) begin
                        o_res_valid      = 1'b1;
                        o_res.frame_done = 1'b1;
                        if (r_fhc && (ck != i_byte)) begin
                            o_res.status     = rfp_pkg::ST_CHECKSUM;
                            o_res.error_info = ck;
                        end
                    end else begin
                        n_phase = rfp_pkg::PH_PAYLOAD;
                    end
                end
                rfp_pkg::PH_PAYLOAD: begin
                    n_sum   = rfp_pkg::sum_add(r_sum, i_byte);
                    n_taken = r_taken + 6'd1;
                    n_left  = (r_left != '0) ? (r_left - 6'd1) : r_left;
                    ck      = ~n_sum;
                    o_res_valid         = 1'b1;
                    o_res.payload_byte  = i_byte;
                    o_res.payload_valid = 1'b1;
                    if (n_left == '0) begin
                        o_res.frame_done = 1'b1;
                        if (r_fhc && (ck != r_check)) begin
                            o_res.status     = rfp_pkg::ST_CHECKSUM;
                            o_res.error_info = ck;
                        end
                    end
                end
                default: begin
                    n_phase = rfp_pkg::PH_RESULT;
                end
            endcase

            o_res.received_count = n_taken;

            if (o_res_valid && o_res.frame_done) begin
                n_phase = rfp_pkg::PH_RESULT;
                n_taken = '0;
                n_left  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rfp_pkg::PH_RESULT;
            r_sum   <= '0;
            r_left  <= '0;
            r_taken <= '0;
            r_check <= '0;
            r_dev   <= '0;
            r_fhc   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_left  <= n_left;
            r_taken <= n_taken;
            r_check <= n_check;
            r_dev   <= n_dev;
            r_fhc   <= n_fhc;
        end
    end

endmodule

// ----- rtl/core/rfp_out_fifo.sv -----
`timescale 1ns / 1ps

module rfp_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  rfp_pkg::t_result    i_wr_data,
    input  logic                i_rd,
    output logic                o_valid,
    output rfp_pkg::t_result    o_data,
    output logic [1:0]          o_count
);

    localparam logic [1:0] LAST_PTR = 2'(rfp_pkg::FIFO_DEPTH - 1);

    rfp_pkg::t_result r_mem [rfp_pkg::FIFO_DEPTH];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       rd_en;

    assign rd_en   = i_rd && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = i_wr  ? ((r_wr_ptr == LAST_PTR) ? 2'd0 : r_wr_ptr + 2'd1) : r_wr_ptr;
        n_rd_ptr = rd_en ? ((r_rd_ptr == LAST_PTR) ? 2'd0 : r_rd_ptr + 2'd1) : r_rd_ptr;
        n_count  = r_count + {1'b0, i_wr} - {1'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/core/reply_frame_parser.sv -----
`timescale 1ns / 1ps

// Reply frame parser: takes one received byte per transfer on the slave
// stream and gives at most one result per byte on the master stream. A
// byte is registered on entry, parsed the next cycle against the frame
// state, and its result lands in a three-entry output queue that drives
// the master stream. A new byte can be taken every cycle: o_s_axis_tready
// stays high as long as the queued results plus the byte still in the
// input register leave a free slot, which with a sink that takes every
// result never throttles. The result queue depth alone sets the stall
// behavior. Configuration is a plain write port that is always ready;
// write it only while no frame is in flight. No clearing pass after
// reset; the block is ready as soon as reset is released.
module reply_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // received bytes
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte

    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                          // [18:11] device_code, [26:19] error_info,
                                          // [32:27] received_count, rest zero
    output logic        o_m_axis_tlast,   // frame_done
    output logic [0:0]  o_m_axis_tuser,   // [0] payload_valid

    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // config registers
    rfp_pkg::t_cfg r_cfg;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic             res_valid;
    rfp_pkg::t_result res;
    rfp_pkg::t_result q_data;
    logic [1:0]       q_count;
    logic [2:0]       occupancy;
    logic             in_xfer;

    assign o_cfg_ready = 1'b1;

    // room check uses only registered state: queued results plus the one
    // byte that may still be turning into a result
    assign occupancy       = {1'b0, q_count} + {2'b00, r_in_valid};
    assign o_s_axis_tready = (occupancy < 3'(rfp_pkg::FIFO_DEPTH));
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_command <= 8'hFF;
            r_cfg.use_checksum     <= 1'b1;
            r_cfg.expected_bytes   <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rfp_pkg::CFG_EXP_CMD:   r_cfg.expected_command <= i_cfg_data;
                rfp_pkg::CFG_USE_CK:    r_cfg.use_checksum     <= i_cfg_data[0];
                rfp_pkg::CFG_EXP_BYTES: r_cfg.expected_bytes   <= i_cfg_data;
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    rfp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rfp_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_valid),
        .i_wr_data (res),
        .i_rd      (i_m_axis_tready),
        .o_valid   (o_m_axis_tvalid),
        .o_data    (q_data),
        .o_count   (q_count)
    );

    assign o_m_axis_tdata = {7'd0, q_data.received_count, q_data.error_info,
                             q_data.device_code, q_data.status, q_data.payload_byte};
    assign o_m_axis_tlast = q_data.frame_done;
    assign o_m_axis_tuser = q_data.payload_valid;

endmodule

// ----- rtl/core/rfp_checker.sv -----
`timescale 1ns / 1ps

module rfp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] o_m_axis_tdata,
    input  logic        o_m_axis_tlast,
    input  logic [0:0]  o_m_axis_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // no payload byte means a zero byte field
    a_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("payload byte set without payload");

    // status only on the last result of a frame
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tdata[10:8] == rfp_pkg::ST_OK)
        else $error("status set mid-frame");

    // device code only on a device error, info only on device or checksum error
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[10:8] != rfp_pkg::ST_DEV_ERR |->
            o_m_axis_tdata[18:11] == 8'd0
            && (o_m_axis_tdata[10:8] == rfp_pkg::ST_CHECKSUM
                || o_m_axis_tdata[26:19] == 8'd0))
        else $error("error fields set on wrong status");

endmodule

bind reply_frame_parser rfp_checker u_rfp_checker (.*);
